// ===== rtl/single_pass_dice_clusterer_assert.svh =====
// Assertion macros used by the checker module of the Dice clusterer.
// Each macro expands to one labeled concurrent assertion clocked by clk and disabled by rst.
`ifndef SINGLE_PASS_DICE_CLUSTERER_ASSERT_SVH
`define SINGLE_PASS_DICE_CLUSTERER_ASSERT_SVH

// Same-cycle implication.
`define SPDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spdc_pkg.sv =====
// Shared types, constants and functions of the Dice clusterer.
// Used by the front, queue, back and top-level modules.
package spdc_pkg;

  localparam int TERM_W           = 64;
  localparam int CNT_W            = 7;
  localparam int DOC_W            = 16;
  localparam int CIDX_W           = 4;
  localparam int THR_W            = 9;
  localparam int OUT_DATA_W       = 40;
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_VOCAB_BITS   = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam logic [THR_W-1:0] THR_RESET = 9'd128;

  typedef enum logic [1:0] {
    ST_JOINED  = 2'd0,
    ST_FOUNDED = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_NEW
  } back_state_t;

  typedef struct packed {
    logic [TERM_W-1:0] terms;
    logic [CNT_W-1:0]  count;
    logic [DOC_W-1:0]  doc;
  } job_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [1:0] pair [4];
    logic [2:0] quad [2];
    for (int i = 0; i < 4; i++) begin
      pair[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      quad[i] = {1'b0, pair[2*i]} + {1'b0, pair[2*i+1]};
    end
    return {1'b0, quad[0]} + {1'b0, quad[1]};
  endfunction

  function automatic logic [CNT_W-1:0] popcount64(input logic [TERM_W-1:0] v);
    logic [3:0] s8  [8];
    logic [4:0] s16 [4];
    logic [5:0] s32 [2];
    for (int b = 0; b < 8; b++) begin
      s8[b] = popcount8(v[8*b +: 8]);
    end
    for (int i = 0; i < 4; i++) begin
      s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s32[i] = {1'b0, s16[2*i]} + {1'b0, s16[2*i+1]};
    end
    return {1'b0, s32[0]} + {1'b0, s32[1]};
  endfunction

endpackage

// ===== rtl/spdc_front.sv =====
// Front part: accepts documents, masks them to the vocabulary, numbers and counts them.
// Depends on spdc_pkg; feeds the job queue.
module spdc_front #(
  parameter int VocabBits = spdc_pkg::DEF_VOCAB_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spdc_pkg::TERM_W-1:0] in_terms,
  output logic                       q_valid,
  input  logic                       q_ready,
  output spdc_pkg::job_t             q_data
);
  import spdc_pkg::*;

  localparam logic [TERM_W-1:0] VocabMask = TERM_W'({VocabBits{1'b1}});

  logic              hold_valid;
  logic [TERM_W-1:0] hold_terms;
  logic [DOC_W-1:0]  hold_doc;
  logic [DOC_W-1:0]  doc_counter;
  logic              take;

  assign in_ready = !hold_valid || q_ready;
  assign take     = in_valid && in_ready;
  assign q_valid  = hold_valid;
  assign q_data   = '{terms: hold_terms, count: popcount64(hold_terms), doc: hold_doc};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid  <= 1'b0;
      doc_counter <= '0;
    end else begin
      if (take) begin
        hold_valid  <= 1'b1;
        doc_counter <= doc_counter + DOC_W'(1);
      end else if (q_ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_terms <= in_terms & VocabMask;
      hold_doc   <= doc_counter;
    end
  end

endmodule

// ===== rtl/spdc_queue.sv =====
// Short job queue between the front and back parts.
// Depends on spdc_pkg for the job type and depth.
module spdc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  spdc_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output spdc_pkg::job_t rd_data
);
  import spdc_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != FillW'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FillW'(1);
      end else if (pop && !push) begin
        fill <= fill - FillW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/spdc_back.sv =====
// Back part: scans the table one entry per cycle unless stalled and issues the result.
// Depends on spdc_pkg; holds the representative memory and the output register.
module spdc_back #(
  parameter int MaxClusters = spdc_pkg::DEF_MAX_CLUSTERS,
  parameter int VocabBits   = spdc_pkg::DEF_VOCAB_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [spdc_pkg::THR_W-1:0]  threshold,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  spdc_pkg::job_t              q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [spdc_pkg::DOC_W-1:0]  out_doc,
  output logic [spdc_pkg::CIDX_W-1:0] out_cidx,
  output logic [spdc_pkg::DOC_W-1:0]  out_rep,
  output spdc_pkg::status_t           out_status
);
  import spdc_pkg::*;

  localparam int CntClW = $clog2(MaxClusters + 1);
  localparam int IdxW   = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int TotW   = CNT_W + 1;
  localparam int ProdW  = THR_W + TotW;

  logic [VocabBits-1:0] mem_terms [MaxClusters];
  logic [CNT_W-1:0]     mem_count [MaxClusters];
  logic [DOC_W-1:0]     mem_doc   [MaxClusters];

  back_state_t          state, state_next;
  logic [CntClW-1:0]    scan_c, scan_c_next, scan_c_inc;
  logic [CntClW-1:0]    cluster_count;
  job_t                 cur;
  logic [VocabBits-1:0] rd_terms;
  logic [CNT_W-1:0]     rd_count;
  logic [DOC_W-1:0]     rd_doc;

  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic                 load_out;
  logic [CIDX_W-1:0]    cidx_next;
  logic [DOC_W-1:0]     rep_next;
  status_t              status_next;
  logic                 out_free;
  logic                 last;
  logic                 meets;
  logic [CNT_W-1:0]     common;
  logic [TotW-1:0]      total;
  logic [ProdW-1:0]     lhs, rhs;

  assign common = popcount64(cur.terms & TERM_W'(rd_terms));
  assign total  = TotW'(cur.count) + TotW'(rd_count);
  assign lhs    = ProdW'({common, 9'b0});
  assign rhs    = ProdW'(threshold) * ProdW'(total);
  assign meets  = (total != '0) && (lhs >= rhs);

  assign out_free   = !out_valid || out_ready;
  assign scan_c_inc = scan_c + CntClW'(1);
  assign last       = scan_c_inc == cluster_count;

  always_comb begin
    state_next  = state;
    scan_c_next = scan_c;
    q_ready     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    load_out    = 1'b0;
    cidx_next   = '0;
    rep_next    = '0;
    status_next = ST_DROPPED;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          rd_en       = 1'b1;
          scan_c_next = '0;
          state_next  = (cluster_count == '0) ? BK_NEW : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (out_free) begin
          if (meets) begin
            load_out    = 1'b1;
            cidx_next   = CIDX_W'(scan_c);
            rep_next    = rd_doc;
            status_next = ST_JOINED;
            state_next  = BK_IDLE;
          end else if (last) begin
            state_next = BK_NEW;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = scan_c_inc[IdxW-1:0];
            scan_c_next = scan_c_inc;
          end
        end
      end
      BK_NEW: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
          if (cluster_count != CntClW'(MaxClusters)) begin
            wr_en       = 1'b1;
            cidx_next   = CIDX_W'(cluster_count);
            rep_next    = cur.doc;
            status_next = ST_FOUNDED;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      scan_c        <= '0;
      cluster_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      scan_c <= scan_c_next;
      if (wr_en) begin
        cluster_count <= cluster_count + CntClW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_data;
    end
    if (load_out) begin
      out_doc    <= cur.doc;
      out_cidx   <= cidx_next;
      out_rep    <= rep_next;
      out_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_terms[cluster_count[IdxW-1:0]] <= cur.terms[VocabBits-1:0];
      mem_count[cluster_count[IdxW-1:0]] <= cur.count;
      mem_doc[cluster_count[IdxW-1:0]]   <= cur.doc;
    end
    if (rd_en) begin
      rd_terms <= mem_terms[rd_addr];
      rd_count <= mem_count[rd_addr];
      rd_doc   <= mem_doc[rd_addr];
    end
  end

endmodule

// ===== rtl/single_pass_dice_clusterer.sv =====
// Single-pass leader clusterer that uses the Dice coefficient on term bitmaps.
// Every document is registered in the front part and then passes through a two-entry
// queue to the back part. The back part fetches the job, compares the representatives
// one by one, and takes a separate final step when the document founds a cluster
// or is dropped. The sustained rate comes from the table scan, which reads one
// representative from memory per cycle while the output is not stalled. Write the
// threshold only while the block is idle.
// Depends on spdc_pkg, spdc_front, spdc_queue and spdc_back.
module single_pass_dice_clusterer #(
  parameter int MAX_CLUSTERS = spdc_pkg::DEF_MAX_CLUSTERS,
  parameter int VOCAB_BITS   = spdc_pkg::DEF_VOCAB_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spdc_pkg::THR_W-1:0]       cfg_data,       // similarity_threshold
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [spdc_pkg::TERM_W-1:0]      s_axis_tdata,   // term_bits
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // doc_index [15:0], cluster_index [19:16], representative_doc [35:20], zero pad
  output logic [spdc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                       m_axis_tuser    // status
);
  import spdc_pkg::*;

  logic [THR_W-1:0]  threshold;
  logic              fq_valid, fq_ready;
  job_t              fq_data;
  logic              qb_valid, qb_ready;
  job_t              qb_data;
  logic [DOC_W-1:0]  out_doc;
  logic [CIDX_W-1:0] out_cidx;
  logic [DOC_W-1:0]  out_rep;
  status_t           out_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  spdc_front #(
    .VocabBits(VOCAB_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_terms (s_axis_tdata),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  spdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  spdc_back #(
    .MaxClusters(MAX_CLUSTERS),
    .VocabBits  (VOCAB_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_doc    (out_doc),
    .out_cidx   (out_cidx),
    .out_rep    (out_rep),
    .out_status (out_status)
  );

  assign m_axis_tdata = {(OUT_DATA_W - 2 * DOC_W - CIDX_W)'(0), out_rep, out_cidx, out_doc};
  assign m_axis_tuser = out_status;

endmodule

// ===== rtl/spdc_checker.sv =====
// Port-level checks of the Dice clusterer's result stream, bound to the top level.
// Depends on spdc_pkg and single_pass_dice_clusterer_assert.svh.
`include "single_pass_dice_clusterer_assert.svh"

module spdc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [spdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);
  import spdc_pkg::*;

  `SPDC_ASSERT_NXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled result changed.")
  `SPDC_ASSERT_IMP(a_status_known, m_axis_tvalid, m_axis_tuser == ST_JOINED || m_axis_tuser == ST_FOUNDED || m_axis_tuser == ST_DROPPED, "Unknown status code.")
  `SPDC_ASSERT_IMP(a_drop_zero, m_axis_tvalid && m_axis_tuser == ST_DROPPED, m_axis_tdata[35:16] == '0, "Dropped item carries a cluster.")
  `SPDC_ASSERT_IMP(a_found_self, m_axis_tvalid && m_axis_tuser == ST_FOUNDED, m_axis_tdata[35:20] == m_axis_tdata[15:0], "Founder is not its own representative.")

endmodule

bind single_pass_dice_clusterer spdc_checker u_spdc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
